/* design/ats_pkg.sv */
// Shared types and constants for the alarm table scheduler.
// No dependencies.
package ats_pkg;

    localparam int unsigned NUM_SLOTS_DEF = 8;
    localparam int unsigned MAX_OUT       = 8;
    localparam int unsigned PER_W         = 22;
    localparam logic [15:0] LATE_RESET    = 16'd60;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_SETDUE = 2'd2;
    localparam logic [1:0] OP_SETEN  = 2'd3;

    localparam logic [2:0] K_NONE   = 3'd0;
    localparam logic [2:0] K_FIRED  = 3'd1;
    localparam logic [2:0] K_CREATE = 3'd2;
    localparam logic [2:0] K_FULL   = 3'd3;
    localparam logic [2:0] K_DONE   = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  slot;
        logic [31:0] now_time;
        logic [31:0] due_time;
        logic        enable_flag;
        logic        repeat_flag;
        logic [15:0] interval_minutes;
    } t_in;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] slot_index;
        logic       last;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture input beat
        logic do_simple;  // perform create / set-due / set-enable
        logic eval;       // evaluate current scan slot
        logic mod_start;  // start the modulo unit
        logic mod_apply;  // write the late repeating result
        logic advance;    // next scan slot
        logic emit;       // end of scan: present the final tick beat
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_tick;
        logic scan_end;   // scan index past last created slot
        logic cand;       // slot is enabled, armed and due
        logic late;
        logic rep;
        logic mod_done;
    } t_sts;

endpackage

/* design/ats_if.sv */
// Valid/ready channel carrying one payload type.
// Depends on nothing but the payload type parameter.
interface ats_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/ats_ctrl.sv */
// Sequencer for the alarm table scheduler.
// Depends on ats_pkg.
module ats_ctrl
    import ats_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.is_tick) begin
                    n_state = S_EVAL;
                end else if (!i_out_busy) begin
                    o_cmd.do_simple = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EVAL: begin
                if (i_sts.scan_end) begin
                    n_state = S_EMIT;
                end else if (i_sts.cand && i_sts.late && i_sts.rep) begin
                    o_cmd.mod_start = 1'b1;
                    n_state = S_MOD;
                end else if (!i_out_busy) begin
                    o_cmd.eval    = 1'b1;
                    o_cmd.advance = 1'b1;
                end
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.mod_apply = 1'b1;
                    o_cmd.advance   = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EMIT: begin
                if (!i_out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_DISP)
        else $error("load did not enter dispatch");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MOD && !i_sts.mod_done |=> r_state == S_MOD)
        else $error("left modulo wait early");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_cmd.eval && !o_cmd.mod_apply)
        else $error("accepted input while scanning");
endmodule

/* design/ats_dp.sv */
// Slot table, scan index, serial modulo unit and result register.
// Depends on ats_pkg.
module ats_dp
    import ats_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  t_in         i_in,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_out_busy,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_out
);
    localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
    localparam int unsigned NW = $clog2(MAX_OUT + 1);

    t_in              r_in;
    logic [15:0]      r_late_limit;
    logic [NUM_SLOTS-1:0] r_en, r_arm, r_rep;
    logic [31:0]      r_due [NUM_SLOTS];
    logic [PER_W-1:0] r_per [NUM_SLOTS];
    logic [CW-1:0]    r_used;
    logic [CW-1:0]    r_idx;
    logic [NW-1:0]    r_nfired;
    logic [2:0]       r_pslot;
    logic             r_valid;
    t_out             r_out;
    // Modulo unit: restoring division, one quotient bit a cycle.
    logic [31:0]      r_rem;
    logic [31:0]      r_num;
    logic [5:0]       r_cnt;
    logic             r_mbusy;

    logic [IW-1:0]    idx;
    logic [31:0]      due_i, lateness;
    logic [PER_W-1:0] per_i;
    logic             cand, late;
    logic [32:0]      trial;
    logic [21:0]      per60;
    logic             fire_rep;
    t_out             simple_out;

    assign idx      = r_idx[IW-1:0];
    assign due_i    = r_due[idx];
    assign per_i    = r_per[idx];
    assign lateness = r_in.now_time - due_i;
    assign cand     = (r_idx < r_used) && r_en[idx] && r_arm[idx]
                      && (r_in.now_time >= due_i);
    assign late     = lateness > {16'd0, r_late_limit};
    assign trial    = {r_rem, r_num[31]} - {11'd0, per_i};
    assign per60    = 22'(({6'd0, r_in.interval_minutes} << 6)
                      - ({6'd0, r_in.interval_minutes} << 2));
    // A slot that fires and still fits in the report count.
    assign fire_rep = i_cmd.eval && cand && !late && (r_nfired < NW'(MAX_OUT));

    assign o_sts.is_tick  = r_in.operation == OP_TICK;
    assign o_sts.scan_end = r_idx >= r_used;
    assign o_sts.cand     = cand;
    assign o_sts.late     = late;
    assign o_sts.rep      = r_rep[idx];
    assign o_sts.mod_done = r_mbusy && r_cnt == 6'd32;

    assign o_out_busy = r_valid && !i_ready;
    assign o_valid    = r_valid;
    assign o_out      = r_out;

    always_comb begin
        simple_out.kind       = K_DONE;
        simple_out.slot_index = r_in.slot;
        simple_out.last       = 1'b1;
        if (r_in.operation == OP_CREATE) begin
            if (r_used < CW'(NUM_SLOTS)) begin
                simple_out.kind       = K_CREATE;
                simple_out.slot_index = 3'(r_used);
            end else begin
                simple_out.kind       = K_FULL;
                simple_out.slot_index = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in;
        if (i_cmd.mod_start) begin
            r_rem <= '0;
            r_num <= lateness;
            r_cnt <= '0;
        end else if (r_mbusy && r_cnt != 6'd32) begin
            r_rem <= trial[32] ? {r_rem[30:0], r_num[31]} : trial[31:0];
            r_num <= {r_num[30:0], 1'b0};
            r_cnt <= r_cnt + 6'd1;
        end
        if (i_cmd.do_simple && r_in.operation == OP_CREATE && r_used < CW'(NUM_SLOTS))
            r_per[r_used[IW-1:0]] <= per60;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) r_due[k] <= '0;
        end else if (i_cmd.do_simple) begin
            if (r_in.operation == OP_SETDUE && 32'(r_in.slot) < NUM_SLOTS)
                r_due[r_in.slot[IW-1:0]] <= r_in.due_time;
        end else if (i_cmd.eval && cand && !late && r_rep[idx]) begin
            r_due[idx] <= due_i + {10'd0, per_i};
        end else if (i_cmd.mod_apply) begin
            r_due[idx] <= r_in.now_time + {10'd0, per_i}
                          - ((per_i != '0) ? r_rem : 32'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_late_limit <= LATE_RESET;
            r_en <= '0; r_arm <= '0; r_rep <= '0;
            r_used <= '0; r_idx <= '0; r_nfired <= '0; r_pslot <= '0;
            r_valid <= 1'b0; r_mbusy <= 1'b0;
        end else begin
            if (i_cfg_we) r_late_limit <= i_cfg_data;
            if (i_cmd.mod_start) r_mbusy <= 1'b1;
            else if (i_cmd.mod_apply) r_mbusy <= 1'b0;
            if (i_cmd.load) r_idx <= '0;
            else if (i_cmd.advance) r_idx <= r_idx + CW'(1);
            if (i_cmd.do_simple && r_in.operation == OP_CREATE
                && r_used < CW'(NUM_SLOTS))
                r_used <= r_used + CW'(1);
            if (i_cmd.do_simple) begin
                case (r_in.operation)
                    OP_CREATE: begin
                        if (r_used < CW'(NUM_SLOTS)) begin
                            r_en[r_used[IW-1:0]]  <= r_in.enable_flag;
                            r_arm[r_used[IW-1:0]] <= 1'b1;
                            r_rep[r_used[IW-1:0]] <= r_in.repeat_flag;
                        end
                    end
                    OP_SETEN: begin
                        if (32'(r_in.slot) < NUM_SLOTS)
                            r_en[r_in.slot[IW-1:0]] <= r_in.enable_flag;
                    end
                    default: ;
                endcase
            end else if (i_cmd.eval && cand && !r_rep[idx]) begin
                r_arm[idx] <= 1'b0;
            end
            // The latest fired slot stays pending until the next fire or the
            // end of the scan, so the final one can carry last.
            if (i_cmd.load) begin
                r_nfired <= '0;
            end else if (fire_rep) begin
                r_pslot  <= 3'(r_idx);
                r_nfired <= r_nfired + NW'(1);
            end
            if (i_cmd.do_simple) begin
                r_valid <= 1'b1;
                r_out   <= simple_out;
            end else if (fire_rep && r_nfired != '0) begin
                r_valid <= 1'b1;
                r_out.kind       <= K_FIRED;
                r_out.slot_index <= r_pslot;
                r_out.last       <= 1'b0;
            end else if (i_cmd.emit) begin
                r_valid <= 1'b1;
                r_out.last <= 1'b1;
                if (r_nfired == '0) begin
                    r_out.kind       <= K_NONE;
                    r_out.slot_index <= 3'd0;
                end else begin
                    r_out.kind       <= K_FIRED;
                    r_out.slot_index <= r_pslot;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mod_apply |-> r_cnt == 6'd32)
        else $error("modulo applied before done");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(NUM_SLOTS))
        else $error("slot count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfired <= NW'(MAX_OUT))
        else $error("fired count overflow");
endmodule

/* design/alarm_table_scheduler.sv */
// Top level of the alarm table scheduler: channels, config inputs, wiring.
// Depends on ats_pkg, ats_if, ats_ctrl and ats_dp.
//
// Usage: input beats arrive on in_ch (operation plus fields); result beats
// leave on out_ch. Create, set-due and set-enable answer with one beat,
// marked last, registered from the dispatch state once the output is free;
// the next input is accepted once the block is back in idle.
// A tick walks the created slots one per cycle while the output is not
// stalled; a late repeating slot first waits for the bit-serial 32-bit
// modulo of its lateness by its period. The final beat of a tick is
// registered from the emit state once the output is free.
// A tick emits one beat per fired slot (at most eight) or one "none fired"
// beat. Each fired slot is held back until the next one fires or the scan
// ends, so the final beat can carry last.
// One input is worked on at a time; ready is high only between inputs.
// late_limit is written through i_cfg_we / i_cfg_data; the user must do so
// only while idle, as the block itself leaves this unenforced.
// Reset (synchronous, active low) empties the table, clears all due times
// and sets late_limit to 60. A stalled receiver holds the scan, but a late
// repeating slot still gets its modulo update; nothing is dropped.
module alarm_table_scheduler
    import ats_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    ats_if.sink         in_ch,
    ats_if.source       out_ch
);
    t_cmd cmd;
    t_sts sts;
    logic out_busy;

    ats_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_out_busy (out_busy),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ats_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_busy (out_busy),
        .o_valid    (out_ch.valid),
        .i_ready    (out_ch.ready),
        .o_out      (out_ch.data)
    );
endmodule
